[rtl/core/sswo_pkg.sv]
// ----------------------------------------------------------------------------
// sswo_pkg
// Shared types, constant tables and lookup functions for the step sequencer
// wavetable oscillator.
// ----------------------------------------------------------------------------
package sswo_pkg;

  // button click counts
  localparam logic [1:0] CLICK_NONE   = 2'd0;
  localparam logic [1:0] CLICK_SINGLE = 2'd1;
  localparam logic [1:0] CLICK_DOUBLE = 2'd2;

  localparam int unsigned INIT_STEPS = 16;

  localparam logic [7:0] LEN_INIT [INIT_STEPS] = '{
    8'd127, 8'd0, 8'd0, 8'd0, 8'd127, 8'd63, 8'd0, 8'd0,
    8'd127, 8'd63, 8'd31, 8'd0, 8'd127, 8'd63, 8'd31, 8'd15
  };

  localparam logic [15:0] PITCH_INIT [INIT_STEPS] = '{
    16'd1830, 16'd1830, 16'd1830, 16'd1830,
    16'd3660, 16'd3660, 16'd3660, 16'd3660,
    16'd7320, 16'd7320, 16'd7320, 16'd7320,
    16'd14640, 16'd14640, 16'd14640, 16'd14640
  };

  // hz*256/122 phase increments, top four entries silent
  localparam logic [15:0] NOTE_TABLE [16] = '{
    16'd230, 16'd308, 16'd346, 16'd411, 16'd461, 16'd616, 16'd692, 16'd822,
    16'd923, 16'd1231, 16'd1382, 16'd1846, 16'd0, 16'd0, 16'd0, 16'd0
  };

  localparam logic [6:0] QUARTER_SINE [65] = '{
    7'd0, 7'd3, 7'd6, 7'd9, 7'd12, 7'd16, 7'd19, 7'd22,
    7'd25, 7'd28, 7'd31, 7'd34, 7'd37, 7'd40, 7'd43, 7'd46,
    7'd49, 7'd51, 7'd54, 7'd57, 7'd60, 7'd63, 7'd65, 7'd68,
    7'd71, 7'd73, 7'd76, 7'd78, 7'd81, 7'd83, 7'd85, 7'd88,
    7'd90, 7'd92, 7'd94, 7'd96, 7'd98, 7'd100, 7'd102, 7'd104,
    7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd115, 7'd116,
    7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
    7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
    7'd127
  };

  // per-tick control results handed to the voice
  typedef struct packed {
    logic        gate;
    logic [15:0] pitch;
    logic [7:0]  tempo;
  } voice_ctrl_t;

  // full sine from the quarter wave: odd quadrants mirrored, upper half below 128
  function automatic logic [7:0] wave_sample(input logic [7:0] idx);
    logic [6:0] k;
    logic [6:0] q;
    k = {1'b0, idx[5:0]};
    q = idx[6] ? QUARTER_SINE[7'd64 - k] : QUARTER_SINE[k];
    return idx[7] ? (8'd128 - {1'b0, q}) : (8'd128 + {1'b0, q});
  endfunction

  // length cycle 0 -> 31 -> 63 -> 127 -> 255 -> 0
  function automatic logic [7:0] next_length(input logic [7:0] len);
    logic [7:0] r;
    if (len < 8'd31) r = 8'd31;
    else if (len < 8'd63) r = 8'd63;
    else if (len < 8'd127) r = 8'd127;
    else if (len < 8'd255) r = 8'd255;
    else r = 8'd0;
    return r;
  endfunction

endpackage

[rtl/core/sswo_voice.sv]
// ----------------------------------------------------------------------------
// sswo_voice
// Phase and step accumulators, wavetable lookup and volume scaling.
// ----------------------------------------------------------------------------
module sswo_voice
  import sswo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  voice_ctrl_t ctrl,
  output logic [21:0] step_count,
  output logic [7:0]  sample
);

  logic [15:0] phase_r;
  logic [15:0] phase_nxt;
  logic [21:0] count_r;
  logic [21:0] count_nxt;
  logic [15:0] product;

  // sample uses the phase before this tick's advance
  assign product    = {8'd0, wave_sample(phase_r[15:8])} * {8'd0, {8{ctrl.gate}}};
  assign sample     = product[15:8];
  assign phase_nxt  = phase_r + ctrl.pitch;
  assign count_nxt  = count_r + {14'd0, ctrl.tempo};
  assign step_count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      count_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/core/step_sequencer_wavetable_osc_top.sv]
// ----------------------------------------------------------------------------
// step_sequencer_wavetable_osc_top
// Sixteen-step sequencer with edit mode driving a sine wavetable voice.
// ----------------------------------------------------------------------------
// One input word is one audio sample tick (knob value plus button event) and
// yields exactly one output word: the scaled sample, the step being played
// or edited, the edit flag and the gate. Each tick is handled at the edge
// that accepts the word: sequencer state, the step tables and the voice
// accumulators update there, and the result lands in the output register.
// One word per cycle is sustained; in_ready drops only while the output
// register is full and out_ready is low. In play mode the knob is the
// tempo added to a 22-bit step counter; counter bits 21..18 select the step
// and bits 17..10 gate it against the step length. A short click enters edit
// mode, where the knob's top nibble picks a note for the edited step, short
// clicks cycle its length, double clicks advance the step and a long single click
// returns to play. The step tables reset to a fixed pattern.
// ----------------------------------------------------------------------------
module step_sequencer_wavetable_osc_top
  import sswo_pkg::*;
#(
  parameter int unsigned STEP_COUNT = 16
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_control,
  input  logic [1:0] in_click_count,
  input  logic       in_long_click,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_sample,
  output logic [3:0] out_current_step,
  output logic       out_edit_mode,
  output logic       out_gate_on
);

  localparam int unsigned STEP_W = $clog2(STEP_COUNT);

  // fold a raw 4-bit step number onto the step range
  function automatic logic [STEP_W-1:0] wrap_step(input logic [3:0] x);
    logic [STEP_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (x == 4'(i)) r = STEP_W'(i % STEP_COUNT);
    end
    return r;
  endfunction

  // step tables
  logic [7:0]  len_r   [STEP_COUNT];
  logic [15:0] pitch_t_r [STEP_COUNT];

  // sequencer state
  logic [7:0]        tempo_r, tempo_nxt;
  logic [15:0]       pitch_r, pitch_nxt;
  logic              editing_r, editing_nxt;
  logic [STEP_W-1:0] edit_r, edit_nxt;

  // output register
  logic       out_valid_r;
  logic [7:0] sample_r;
  logic [3:0] step_r;
  logic       edit_mode_r;
  logic       gate_r;

  logic              accept;
  logic [21:0]       step_count;
  logic [7:0]        sub;
  logic [STEP_W-1:0] play_idx;
  logic [STEP_W-1:0] cur_edit;
  logic [STEP_W-1:0] rd_idx;
  logic [7:0]        rd_len;
  logic [15:0]       rd_pitch;
  logic              gate;
  logic              len_we;
  logic              pitch_we;
  logic [3:0]        cur_step_nxt;
  logic [7:0]        voice_sample;
  voice_ctrl_t       vctrl;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign sub      = step_count[17:10];
  assign play_idx = wrap_step(step_count[21:18]);
  assign cur_edit = wrap_step(4'(edit_r));
  // one table read per tick: edited step in edit mode, else the played one
  assign rd_idx   = editing_r ? cur_edit : play_idx;
  assign rd_len   = len_r[rd_idx];
  assign rd_pitch = pitch_t_r[rd_idx];
  assign gate     = rd_len > sub;

  always_comb begin
    tempo_nxt   = tempo_r;
    pitch_nxt   = pitch_r;
    editing_nxt = editing_r;
    edit_nxt    = edit_r;
    len_we      = 1'b0;
    pitch_we    = 1'b0;
    if (!editing_r) begin
      tempo_nxt = in_control;
      if (gate) pitch_nxt = rd_pitch;
      if (!in_long_click && in_click_count == CLICK_SINGLE) begin
        edit_nxt    = play_idx;
        pitch_nxt   = rd_pitch;
        editing_nxt = 1'b1;
      end
    end else begin
      edit_nxt  = cur_edit;
      pitch_nxt = NOTE_TABLE[in_control[7:4]];
      pitch_we  = 1'b1;
      if (!in_long_click) begin
        if (in_click_count == CLICK_SINGLE) begin
          len_we = 1'b1;
        end else if (in_click_count == CLICK_DOUBLE) begin
          edit_nxt = (cur_edit == STEP_W'(STEP_COUNT - 1)) ? '0
                                                            : cur_edit + STEP_W'(1);
        end
      end else if (in_click_count == CLICK_SINGLE) begin
        editing_nxt = 1'b0;
      end
    end
  end

  assign cur_step_nxt = editing_nxt ? 4'(edit_nxt) : 4'(play_idx);

  assign vctrl.gate  = gate;
  assign vctrl.pitch = pitch_nxt;
  assign vctrl.tempo = tempo_nxt;

  sswo_voice u_voice (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (accept),
    .ctrl       (vctrl),
    .step_count (step_count),
    .sample     (voice_sample)
  );

  // step tables reset to the factory pattern
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STEP_COUNT; i++) begin
        len_r[i]     <= LEN_INIT[i];
        pitch_t_r[i] <= PITCH_INIT[i];
      end
    end else if (accept) begin
      if (len_we)   len_r[cur_edit]     <= next_length(rd_len);
      if (pitch_we) pitch_t_r[cur_edit] <= pitch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r   <= 8'd1;
      pitch_r   <= '0;
      editing_r <= 1'b0;
      edit_r    <= '0;
    end else if (accept) begin
      tempo_r   <= tempo_nxt;
      pitch_r   <= pitch_nxt;
      editing_r <= editing_nxt;
      edit_r    <= edit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r    <= voice_sample;
      step_r      <= cur_step_nxt;
      edit_mode_r <= editing_nxt;
      gate_r      <= gate;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = sample_r;
  assign out_current_step = step_r;
  assign out_edit_mode    = edit_mode_r;
  assign out_gate_on      = gate_r;

  // short click in play mode enters edit mode
  a_enter_edit: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !editing_r && !in_long_click && in_click_count == CLICK_SINGLE
    |=> editing_r)
    else $error("short click did not enter edit mode");

  // long single click in edit mode returns to play
  a_leave_edit: assert property (@(posedge clk) disable iff (!rst_n)
    accept && editing_r && in_long_click && in_click_count == CLICK_SINGLE
    |=> !editing_r)
    else $error("long click did not leave edit mode");

  // tempo follows the knob in play mode only
  a_tempo: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !editing_r |=> tempo_r == $past(in_control))
    else $error("tempo not taken from knob in play mode");

  // reported edit flag matches the sequencer mode
  a_edit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_edit_mode == editing_r)
    else $error("edit flag out of step with mode");

endmodule
